[rtl/core/ihw_pkg.sv]
// Shared types and constants for the inverse 2D Haar wavelet core.
`timescale 1ns / 1ps

package ihw_pkg;

  localparam int STORE_WORDS = 65536;
  localparam int ST_AW       = $clog2(STORE_WORDS);
  localparam int PTR_W       = ST_AW + 2;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_STRIDE = 2'd2;
  localparam logic [1:0] CFG_MAXV   = 2'd3;

  localparam logic [15:0] W14_LIMIT  = 16'h4000;
  localparam logic [15:0] HALF_RANGE = 16'h8000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] word_address;
    logic [15:0] load_value;
  } ihw_in_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic        status;
  } ihw_out_t;

endpackage

[rtl/core/ihw_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module ihw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/ihw_lift.sv]
// Single Haar lifting step, 14-bit signed or modulo-65536 form.
`timescale 1ns / 1ps

module ihw_lift (
  input  logic        w14_i,
  input  logic [15:0] lo_i,
  input  logic [15:0] hi_i,
  output logic [15:0] a_o,
  output logic [15:0] b_o
);

  logic [15:0] half;
  logic [15:0] av;
  logic [15:0] bv;

  always_comb begin
    half = {hi_i[15], hi_i[15:1]};
    av   = lo_i + {15'd0, hi_i[0]} + half;
    bv   = lo_i - {1'b0, hi_i[15:1]};
    if (w14_i) begin
      a_o = av;
      b_o = av - hi_i;
    end else begin
      b_o = bv;
      a_o = hi_i + bv - ihw_pkg::HALF_RANGE;
    end
  end

endmodule

[rtl/core/inverse_haar_wavelet_2d_piz_core.sv]
// Top level of the inverse 2D Haar wavelet (PIZ) core with its coefficient store.
`timescale 1ns / 1ps

// A request carries a mode: load writes one word into the coefficient store, read
// returns one stored word, start runs the in-place inverse wavelet over the block
// set up in the configuration registers, and every request gives exactly one
// result. A start goes over all levels and components: each 2x2 group reads its
// words one at a time, runs four lifting steps through one shared lifting unit
// and writes the words back. No new request is taken during a start. The store
// has no reset; a start whose block does not fit the store answers status 1 and
// leaves the store alone. Configuration must be written only while the core is
// idle; the core itself does not enforce this.

module inverse_haar_wavelet_2d_piz_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ihw_pkg::ihw_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ihw_pkg::ihw_out_t out_data_o
);

  localparam int PW = ihw_pkg::PTR_W;
  localparam int AW = ihw_pkg::ST_AW;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_RDW     = 5'd1;
  localparam logic [4:0] S_MUL1    = 5'd2;
  localparam logic [4:0] S_MUL2    = 5'd3;
  localparam logic [4:0] S_CMP     = 5'd4;
  localparam logic [4:0] S_CINIT   = 5'd5;
  localparam logic [4:0] S_GROW    = 5'd6;
  localparam logic [4:0] S_LSTART  = 5'd7;
  localparam logic [4:0] S_ROWCHK  = 5'd8;
  localparam logic [4:0] S_COLCHK  = 5'd9;
  localparam logic [4:0] S_RTAIL   = 5'd10;
  localparam logic [4:0] S_RD      = 5'd11;
  localparam logic [4:0] S_RDL     = 5'd12;
  localparam logic [4:0] S_LIFT    = 5'd13;
  localparam logic [4:0] S_WR      = 5'd14;
  localparam logic [4:0] S_ROWADV  = 5'd15;
  localparam logic [4:0] S_LNEXT   = 5'd16;
  localparam logic [4:0] S_CNEXT   = 5'd17;

  localparam logic [1:0] PH_BLK   = 2'd0;
  localparam logic [1:0] PH_CTAIL = 2'd1;
  localparam logic [1:0] PH_RTAIL = 2'd2;

  // configuration
  logic [12:0] width_q, height_q;
  logic [1:0]  stride_q;
  logic [15:0] maxv_q;

  // sequencer
  logic [4:0]    state_q, state_d;
  logic [14:0]   oy_q, oy_d;
  logic [27:0]   tot_q, tot_d;
  logic [1:0]    j_q, j_d;
  logic [12:0]   p_q, p_d;
  logic [PW-1:0] ox1_q, ox1_d, oy1_q, oy1_d;
  logic [13:0]   x_q, x_d, y_q, y_d;
  logic [PW-1:0] px_q, px_d, py_q, py_d;
  logic [PW-1:0] a_q [4];
  logic [PW-1:0] a_d [4];
  logic [15:0]   v_q [4];
  logic [15:0]   v_d [4];
  logic [1:0]    k_q, k_d, ls_q, ls_d, phase_q, phase_d;
  logic          pair_q, pair_d, w14_q, w14_d, rd_ok_q, rd_ok_d;
  logic          out_valid_q, out_valid_d;
  ihw_pkg::ihw_out_t out_q, out_d;

  // datapath
  logic          in_acc, out_acc, addr_ok;
  logic [12:0]   n_min;
  logic [13:0]   p2;
  logic [14:0]   x_end, y_end;
  logic          col_fit, row_fit, nx_odd, ny_odd;
  logic [1:0]    k_last, lo_idx, hi_idx;
  logic [15:0]   lift_a, lift_b;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign addr_ok = 32'(in_data_i.word_address) < 32'(ihw_pkg::STORE_WORDS);
  assign n_min   = (width_q < height_q) ? width_q : height_q;
  assign p2      = {p_q, 1'b0};
  assign x_end   = {1'b0, x_q} + {1'b0, p2};
  assign y_end   = {1'b0, y_q} + {1'b0, p2};
  assign col_fit = x_end <= {2'b00, width_q};
  assign row_fit = y_end <= {2'b00, height_q};
  assign nx_odd  = |(width_q & p_q);
  assign ny_odd  = |(height_q & p_q);
  assign k_last  = pair_q ? 2'd1 : 2'd3;

  always_comb begin
    case (ls_q)
      2'd0: begin lo_idx = 2'd0; hi_idx = 2'd2; end
      2'd1: begin lo_idx = 2'd1; hi_idx = 2'd3; end
      2'd2: begin lo_idx = 2'd0; hi_idx = 2'd1; end
      2'd3: begin lo_idx = 2'd2; hi_idx = 2'd3; end
      default: begin lo_idx = 2'd0; hi_idx = 2'd1; end
    endcase
  end

  ihw_lift u_lift (
    .w14_i (w14_q),
    .lo_i  (v_q[lo_idx]),
    .hi_i  (v_q[hi_idx]),
    .a_o   (lift_a),
    .b_o   (lift_b)
  );

  always_comb begin
    if (state_q == S_WR) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(a_q[k_q]);
      ram_wdata = v_q[k_q];
    end else begin
      ram_we    = in_acc && (in_data_i.mode == ihw_pkg::MODE_LOAD) && addr_ok;
      ram_waddr = AW'(in_data_i.word_address);
      ram_wdata = in_data_i.load_value;
    end
    if (state_q == S_RD) begin
      ram_raddr = AW'(a_q[k_q]);
    end else begin
      ram_raddr = AW'(in_data_i.word_address);
    end
  end

  ihw_ram #(
    .WIDTH (16),
    .DEPTH (ihw_pkg::STORE_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    oy_d        = oy_q;
    tot_d       = tot_q;
    j_d         = j_q;
    p_d         = p_q;
    ox1_d       = ox1_q;
    oy1_d       = oy1_q;
    x_d         = x_q;
    y_d         = y_q;
    px_d        = px_q;
    py_d        = py_q;
    a_d         = a_q;
    v_d         = v_q;
    k_d         = k_q;
    ls_d        = ls_q;
    phase_d     = phase_q;
    pair_d      = pair_q;
    w14_d       = w14_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q && !out_acc;
    out_d       = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.mode)
            ihw_pkg::MODE_READ: begin
              rd_ok_d = addr_ok;
              state_d = S_RDW;
            end
            ihw_pkg::MODE_START: begin
              w14_d = maxv_q < ihw_pkg::W14_LIMIT;
              if (width_q == '0 || height_q == '0 || stride_q == '0) begin
                out_valid_d = 1'b1;
                out_d       = '0;
              end else begin
                state_d = S_MUL1;
              end
            end
            default: begin
              out_valid_d = 1'b1;
              out_d       = '0;
            end
          endcase
        end
      end
      S_RDW: begin
        out_valid_d      = 1'b1;
        out_d.read_value = rd_ok_q ? ram_rdata : 16'd0;
        out_d.status     = 1'b0;
        state_d          = S_IDLE;
      end
      S_MUL1: begin
        oy_d    = 15'(width_q) * 15'(stride_q);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        tot_d   = 28'(oy_q) * 28'(height_q);
        state_d = S_CMP;
      end
      S_CMP: begin
        if (32'(tot_q) > 32'(ihw_pkg::STORE_WORDS)) begin
          out_valid_d = 1'b1;
          out_d       = '{read_value: 16'd0, status: 1'b1};
          state_d     = S_IDLE;
        end else begin
          j_d     = 2'd0;
          state_d = S_CINIT;
        end
      end
      S_CINIT: begin
        if (n_min < 13'd2) begin
          state_d = S_CNEXT;
        end else begin
          p_d     = 13'd1;
          ox1_d   = PW'(stride_q);
          oy1_d   = PW'(oy_q);
          state_d = S_GROW;
        end
      end
      S_GROW: begin
        if ({p_q, 2'b00} <= {2'b00, n_min}) begin
          p_d   = {p_q[11:0], 1'b0};
          ox1_d = {ox1_q[PW-2:0], 1'b0};
          oy1_d = {oy1_q[PW-2:0], 1'b0};
        end else begin
          state_d = S_LSTART;
        end
      end
      S_LSTART: begin
        y_d     = '0;
        py_d    = PW'(j_q);
        state_d = S_ROWCHK;
      end
      S_ROWCHK: begin
        x_d  = '0;
        px_d = py_q;
        if (row_fit) begin
          state_d = S_COLCHK;
        end else if (ny_odd) begin
          state_d = S_RTAIL;
        end else begin
          state_d = S_LNEXT;
        end
      end
      S_COLCHK: begin
        k_d = 2'd0;
        if (col_fit) begin
          a_d[0]  = px_q;
          a_d[1]  = px_q + ox1_q;
          a_d[2]  = px_q + oy1_q;
          a_d[3]  = px_q + oy1_q + ox1_q;
          pair_d  = 1'b0;
          phase_d = PH_BLK;
          state_d = S_RD;
        end else if (nx_odd) begin
          a_d[0]  = px_q;
          a_d[1]  = px_q + oy1_q;
          pair_d  = 1'b1;
          phase_d = PH_CTAIL;
          state_d = S_RD;
        end else begin
          state_d = S_ROWADV;
        end
      end
      S_RTAIL: begin
        k_d = 2'd0;
        if (col_fit) begin
          a_d[0]  = px_q;
          a_d[1]  = px_q + ox1_q;
          pair_d  = 1'b1;
          phase_d = PH_RTAIL;
          state_d = S_RD;
        end else begin
          state_d = S_LNEXT;
        end
      end
      S_RD: begin
        if (k_q != 2'd0) begin
          v_d[2'(k_q - 2'd1)] = ram_rdata;
        end
        k_d = k_q + 2'd1;
        if (k_q == k_last) begin
          state_d = S_RDL;
        end
      end
      S_RDL: begin
        v_d[k_last] = ram_rdata;
        ls_d        = pair_q ? 2'd2 : 2'd0;
        state_d     = S_LIFT;
      end
      S_LIFT: begin
        v_d[lo_idx] = lift_a;
        v_d[hi_idx] = lift_b;
        ls_d        = ls_q + 2'd1;
        if (pair_q || ls_q == 2'd3) begin
          k_d     = 2'd0;
          state_d = S_WR;
        end
      end
      S_WR: begin
        k_d = k_q + 2'd1;
        if (k_q == k_last) begin
          case (phase_q)
            PH_BLK: begin
              x_d     = 14'(x_end);
              px_d    = px_q + {ox1_q[PW-2:0], 1'b0};
              state_d = S_COLCHK;
            end
            PH_RTAIL: begin
              x_d     = 14'(x_end);
              px_d    = px_q + {ox1_q[PW-2:0], 1'b0};
              state_d = S_RTAIL;
            end
            default: begin
              state_d = S_ROWADV;
            end
          endcase
        end
      end
      S_ROWADV: begin
        y_d     = 14'(y_end);
        py_d    = py_q + {oy1_q[PW-2:0], 1'b0};
        state_d = S_ROWCHK;
      end
      S_LNEXT: begin
        if (p_q == 13'd1) begin
          state_d = S_CNEXT;
        end else begin
          p_d     = {1'b0, p_q[12:1]};
          ox1_d   = {1'b0, ox1_q[PW-1:1]};
          oy1_d   = {1'b0, oy1_q[PW-1:1]};
          state_d = S_LSTART;
        end
      end
      S_CNEXT: begin
        if (j_q + 2'd1 == stride_q) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          state_d     = S_IDLE;
        end else begin
          j_d     = j_q + 2'd1;
          state_d = S_CINIT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 13'd1;
      height_q    <= 13'd1;
      stride_q    <= 2'd1;
      maxv_q      <= 16'd0;
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ihw_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[12:0];
          ihw_pkg::CFG_HEIGHT: height_q <= cfg_data_i[12:0];
          ihw_pkg::CFG_STRIDE: stride_q <= cfg_data_i[1:0];
          ihw_pkg::CFG_MAXV:   maxv_q   <= cfg_data_i;
          default: ;
        endcase
      end
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oy_q    <= oy_d;
    tot_q   <= tot_d;
    j_q     <= j_d;
    p_q     <= p_d;
    ox1_q   <= ox1_d;
    oy1_q   <= oy1_d;
    x_q     <= x_d;
    y_q     <= y_d;
    px_q    <= px_d;
    py_q    <= py_d;
    a_q     <= a_d;
    v_q     <= v_d;
    k_q     <= k_d;
    ls_q    <= ls_d;
    phase_q <= phase_d;
    pair_q  <= pair_d;
    w14_q   <= w14_d;
    rd_ok_q <= rd_ok_d;
    out_q   <= out_d;
  end

  a_read_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.mode == ihw_pkg::MODE_READ |-> ##2 out_valid_q)
    else $error("read request gave no result");

  a_load_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.mode == ihw_pkg::MODE_LOAD
    |=> out_valid_q && out_q.read_value == 16'd0 && !out_q.status)
    else $error("load request gave a wrong result");

  a_store_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_WR || state_q == S_IDLE)
    else $error("store written outside a write phase");

  a_pair_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LIFT && pair_q |-> ls_q == 2'd2)
    else $error("edge pair took a block lifting step");

  a_status_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status |-> out_q.read_value == 16'd0)
    else $error("size error carried data");

endmodule

[bench/testbench.sv]
// Self-checking testbench for the inverse 2D Haar wavelet core: load, decode, read back.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TARGET_ITEMS = 1350;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = ihw_pkg::CFG_WIDTH;
  logic [15:0]       cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  ihw_pkg::ihw_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  ihw_pkg::ihw_out_t out_data_o;

  inverse_haar_wavelet_2d_piz_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // shadow of the block's registers, updated on each register write
  logic [12:0] blk_w = 13'd1;
  logic [12:0] blk_h = 13'd1;
  logic [1:0]  blk_s = 2'd1;
  logic [15:0] blk_maxv = '0;

  bit [15:0] coef_model [0:ihw_pkg::STORE_WORDS-1];
  bit        planned [0:ihw_pkg::STORE_WORDS-1];
  int        planned_addrs [$];

  ihw_pkg::ihw_in_t  req_backlog [$];
  ihw_pkg::ihw_out_t expected_answers [$];
  ihw_pkg::ihw_out_t want;

  int req_issued = 0;
  int req_taken = 0;
  int res_taken = 0;
  int fail_cnt = 0;
  int items_made = 0;
  int cyc = 0;
  int idle_run = 0;
  int seen_req = 0;
  int seen_res = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic quiet;

  assign quiet = (cyc >= 3000) && (cyc < 7000);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] mem_rd(longint unsigned i);
    return (i < ihw_pkg::STORE_WORDS) ? coef_model[i] : 16'h0000;
  endfunction

  function automatic void mem_wr(longint unsigned i, logic [15:0] v);
    if (i < ihw_pkg::STORE_WORDS) coef_model[i] = v;
  endfunction

  function automatic void haar_lift(input bit w14, input logic [15:0] lo, input logic [15:0] hi,
                                    output logic [15:0] a, output logic [15:0] b);
    logic [15:0] half;
    if (w14) begin
      half = {hi[15], hi[15:1]};
      a = lo + {15'd0, hi[0]} + half;
      b = a - hi;
    end else begin
      b = lo - {1'b0, hi[15:1]};
      a = hi + b - ihw_pkg::HALF_RANGE;
    end
  endfunction

  function automatic void inverse_haar_component(longint unsigned base, longint unsigned nx,
                                                 longint unsigned ny, longint unsigned ox,
                                                 longint unsigned oy, bit w14);
    longint unsigned n, p, p2, ey, oy1, oy2, ox1, ox2, py, px, ex, q01, q10, q11;
    logic [15:0] i00, i01, i10, i11, t, r00, r01, r10, r11;
    n = (nx > ny) ? ny : nx;
    p = 1;
    while (p <= n) p = p << 1;
    p = p >> 1;
    p2 = p;
    p = p >> 1;
    while (p >= 1) begin
      ey  = base + oy * (ny - p2);
      oy1 = oy * p;
      oy2 = oy * p2;
      ox1 = ox * p;
      ox2 = ox * p2;
      for (py = base; py <= ey; py += oy2) begin
        ex = py + ox * (nx - p2);
        for (px = py; px <= ex; px += ox2) begin
          q01 = px + ox1;
          q10 = px + oy1;
          q11 = q10 + ox1;
          haar_lift(w14, mem_rd(px), mem_rd(q10), i00, i10);
          haar_lift(w14, mem_rd(q01), mem_rd(q11), i01, i11);
          haar_lift(w14, i00, i01, r00, r01);
          haar_lift(w14, i10, i11, r10, r11);
          mem_wr(px, r00);
          mem_wr(q01, r01);
          mem_wr(q10, r10);
          mem_wr(q11, r11);
        end
        // odd column count: last column pairs vertically only
        if ((nx & p) != 0) begin
          q10 = px + oy1;
          haar_lift(w14, mem_rd(px), mem_rd(q10), i00, t);
          mem_wr(q10, t);
          mem_wr(px, i00);
        end
      end
      // odd row count: last row pairs horizontally only
      if ((ny & p) != 0) begin
        ex = py + ox * (nx - p2);
        for (px = py; px <= ex; px += ox2) begin
          q01 = px + ox1;
          haar_lift(w14, mem_rd(px), mem_rd(q01), i00, t);
          mem_wr(q01, t);
          mem_wr(px, i00);
        end
      end
      p2 = p;
      p = p >> 1;
    end
  endfunction

  function automatic logic run_inverse();
    longint unsigned w, h, s;
    w = blk_w;
    h = blk_h;
    s = blk_s;
    if (w == 0 || h == 0 || s == 0) return 1'b0;
    if (w * h * s > ihw_pkg::STORE_WORDS) return 1'b1;
    for (longint unsigned c = 0; c < s; c++)
      inverse_haar_component(c, w, h, s, w * s, blk_maxv < ihw_pkg::W14_LIMIT);
    return 1'b0;
  endfunction

  function automatic ihw_pkg::ihw_out_t answer_request(ihw_pkg::ihw_in_t rq);
    ihw_pkg::ihw_out_t ans;
    ans = '0;
    case (rq.mode)
      ihw_pkg::MODE_LOAD:  mem_wr(rq.word_address, rq.load_value);
      ihw_pkg::MODE_START: ans.status = run_inverse();
      ihw_pkg::MODE_READ:  ans.read_value = mem_rd(rq.word_address);
      default: ;
    endcase
    return ans;
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'h4000;
      5: return 16'h3FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_maxv();
    case ($urandom_range(5))
      0: return 0;
      1: return 16383;
      2: return 16384;
      3: return 65535;
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic push_req(input logic [1:0] md, input logic [15:0] adr, input logic [15:0] val);
    ihw_pkg::ihw_in_t rq;
    rq.mode = md;
    rq.word_address = adr;
    rq.load_value = val;
    req_backlog = {req_backlog, rq};
    if (md != MODE_SPARE) items_made++;
    if (md == ihw_pkg::MODE_LOAD && !planned[adr]) begin
      planned[adr] = 1'b1;
      planned_addrs = {planned_addrs, int'(adr)};
    end
  endtask

  task automatic random_noise();
    case ($urandom_range(4))
      0, 1: push_req(ihw_pkg::MODE_LOAD, 16'($urandom), rand_word());
      2, 3: push_req(ihw_pkg::MODE_READ,
                     16'(planned_addrs[$urandom_range(planned_addrs.size() - 1)]),
                     16'($urandom));
      default: push_req(MODE_SPARE, 16'($urandom), 16'($urandom));
    endcase
  endtask

  task automatic settle();
    while (req_backlog.size() != 0 || in_valid_i || expected_answers.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_block(input int w, input int h, input int s, input int mv);
    settle();
    write_cfg(ihw_pkg::CFG_WIDTH, 16'(w));
    write_cfg(ihw_pkg::CFG_HEIGHT, 16'(h));
    write_cfg(ihw_pkg::CFG_STRIDE, 16'(s));
    write_cfg(ihw_pkg::CFG_MAXV, 16'(mv));
  endtask

  // load the block (fresh data, or the gaps and some random words), decode, read it all back
  task automatic plan_phase(input int w, input int h, input int s, input int mv);
    int words;
    bit fresh;
    set_block(w, h, s, mv);
    words = w * h * s;
    if (w == 0 || h == 0 || s == 0 || words > ihw_pkg::STORE_WORDS) words = 0;
    fresh = $urandom_range(9) < 7;
    for (int a = 0; a < words; a++)
      if (fresh || !planned[a] || $urandom_range(3) == 0)
        push_req(ihw_pkg::MODE_LOAD, 16'(a), rand_word());
    repeat ($urandom_range(3)) random_noise();
    push_req(ihw_pkg::MODE_START, 16'($urandom), 16'($urandom));
    for (int a = 0; a < words; a++) push_req(ihw_pkg::MODE_READ, 16'(a), 16'($urandom));
    if ($urandom_range(2) == 0) begin
      push_req(ihw_pkg::MODE_START, 16'($urandom), 16'($urandom));
      for (int a = 0; a < words; a++)
        if ($urandom_range(1) == 0) push_req(ihw_pkg::MODE_READ, 16'(a), 16'($urandom));
    end
    repeat ($urandom_range(4)) random_noise();
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken == req_issued)) begin
      if (req_backlog.size() != 0 && (quiet || $urandom_range(99) >= 18)) begin
        in_data_i  <= req_backlog.pop_front();
        in_valid_i <= 1'b1;
        req_issued++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off while requests keep coming
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (!hold_done && res_taken >= 300 && req_backlog.size() >= 40) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 18);
    end
  end

  // monitor: register shadow, prediction and result check
  always @(posedge clk_i) begin
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ihw_pkg::CFG_WIDTH:  blk_w = cfg_data_i[12:0];
        ihw_pkg::CFG_HEIGHT: blk_h = cfg_data_i[12:0];
        ihw_pkg::CFG_STRIDE: blk_s = cfg_data_i[1:0];
        ihw_pkg::CFG_MAXV:   blk_maxv = cfg_data_i;
        default: ;
      endcase
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_answers = {expected_answers, answer_request(in_data_i)};
      req_taken++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      res_taken++;
      if (expected_answers.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result: read_value %h status %b",
                   out_data_o.read_value, out_data_o.status);
      end else begin
        want = expected_answers.pop_front();
        if (out_data_o.read_value !== want.read_value) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result %0d read_value: expected %h got %h",
                     res_taken, want.read_value, out_data_o.read_value);
        end
        if (out_data_o.status !== want.status) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result %0d status: expected %b got %b",
                     res_taken, want.status, out_data_o.status);
        end
      end
    end
  end

  // watchdog on cycles without progress while work is outstanding
  always @(negedge clk_i) begin
    cyc++;
    if (req_taken != seen_req || res_taken != seen_res ||
        (req_backlog.size() == 0 && !in_valid_i && expected_answers.size() == 0))
      idle_run = 0;
    else
      idle_run++;
    seen_req = req_taken;
    seen_res = res_taken;
    if (idle_run >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int rs, rsel;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // address and data extremes under reset settings
    push_req(ihw_pkg::MODE_LOAD, 16'h0000, 16'hFFFF);
    push_req(ihw_pkg::MODE_LOAD, 16'hFFFF, 16'h0000);
    push_req(ihw_pkg::MODE_LOAD, 16'hAAAA, 16'h5555);
    push_req(ihw_pkg::MODE_LOAD, 16'h5555, 16'hAAAA);
    push_req(ihw_pkg::MODE_LOAD, 16'h8000, 16'h8000);
    push_req(ihw_pkg::MODE_READ, 16'hFFFF, 16'hFFFF);
    push_req(ihw_pkg::MODE_READ, 16'h0000, 16'h0000);
    push_req(ihw_pkg::MODE_READ, 16'hAAAA, 16'h0000);
    push_req(ihw_pkg::MODE_READ, 16'h5555, 16'h0000);
    push_req(ihw_pkg::MODE_READ, 16'h8000, 16'h0000);
    push_req(MODE_SPARE, 16'hFFFF, 16'hFFFF);
    push_req(ihw_pkg::MODE_START, 16'h0000, 16'h0000);
    push_req(ihw_pkg::MODE_READ, 16'h0000, 16'h0000);

    // zero dimensions do nothing
    set_block(0, 1, 1, 0);
    push_req(ihw_pkg::MODE_START, 16'h0000, 16'h0000);
    set_block(1, 0, 1, 0);
    push_req(ihw_pkg::MODE_START, 16'h0000, 16'h0000);
    set_block(1, 1, 0, 0);
    push_req(ihw_pkg::MODE_START, 16'h0000, 16'h0000);

    // blocks too large for the store
    set_block(4096, 4096, 1, 65535);
    push_req(ihw_pkg::MODE_START, 16'h0000, 16'h0000);
    set_block(8191, 8191, 3, 16383);
    push_req(ihw_pkg::MODE_START, 16'hFFFF, 16'hFFFF);
    push_req(ihw_pkg::MODE_READ, 16'h0000, 16'h0000);

    plan_phase(2, 2, 1, 0);
    plan_phase(2, 2, 1, 65535);
    plan_phase(3, 3, 3, 16383);
    plan_phase(5, 3, 2, 16384);
    plan_phase(1, 9, 1, pick_maxv());
    plan_phase(9, 1, 2, pick_maxv());
    plan_phase(7, 12, 2, pick_maxv());
    plan_phase(16, 16, 1, pick_maxv());

    while (items_made < TARGET_ITEMS) begin
      rsel = $urandom_range(9);
      rs = (rsel == 0) ? 3 : ((rsel < 5) ? 1 : 2);
      plan_phase($urandom_range(1, 10), $urandom_range(1, 10), rs, pick_maxv());
    end

    settle();
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0 && expected_answers.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/core/ihw_pkg.sv
rtl/core/ihw_ram.sv
rtl/core/ihw_lift.sv
rtl/core/inverse_haar_wavelet_2d_piz_core.sv
bench/testbench.sv
